### hdl/map_text_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the map text tokenizer
// Concurrent checks on one clock with an active-low reset; empty bodies
// when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MAP_TEXT_TOKENIZER_ASSERT_SVH
`define MAP_TEXT_TOKENIZER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MTT_ASSERT(label, clk, rst_n, prop, msg)
`define MTT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hdl/mtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types, character codes and queue sizes of the map text tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

	localparam logic [7:0] ChNewline   = 8'h0A;
	localparam logic [7:0] ChSlash     = 8'h2F;
	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChSpace     = 8'h20;
	localparam logic [7:0] ChTab       = 8'h09;
	localparam logic [7:0] ChCr        = 8'h0D;

	localparam int QDepth  = 4;
	localparam int QPtrW   = $clog2(QDepth);
	localparam int QLevelW = $clog2(QDepth + 1);

	typedef struct packed {
		logic [7:0] token_byte;
		logic       byte_present;
		logic       token_end;
		logic       run_last;
	} mtt_result_t;

	typedef struct packed {
		logic [1:0]  count;
		mtt_result_t res_a;
		mtt_result_t res_b;
	} mtt_push_t;

	typedef struct packed {
		logic [QLevelW-1:0] level;
	} mtt_qstat_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
	endfunction

endpackage

### hdl/mtt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_in_if
// Text byte channel: valid/ready with one raw byte and an end-of-text mark.
// ----------------------------------------------------------------------------
interface mtt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_input;

	modport source (output valid, output text_byte, output end_of_input, input ready);
	modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

### hdl/mtt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_out_if
// Token channel: valid/ready with one token byte and its end marks.
// ----------------------------------------------------------------------------
interface mtt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_byte;
	logic       byte_present;
	logic       token_end;
	logic       run_last;

	modport source (output valid, output token_byte, output byte_present,
		output token_end, output run_last, input ready);
	modport sink   (input valid, input token_byte, input byte_present,
		input token_end, input run_last, output ready);
endinterface

### hdl/mtt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_core
// Tokenizer state and the per-byte decision; yields up to two results per
// word processed.
// ----------------------------------------------------------------------------
module mtt_core
	import mtt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] c,
	input  logic       eoi,
	output mtt_push_t  push
);

	logic       token_q, quote_q, comment_q, seen_q, held_v_q, tho_q;
	logic [7:0] prev_q, held_b_q;

	logic       token_n, quote_n, comment_n, held_v_n, tho_n;
	logic [7:0] held_b_n;
	logic       fin, emit_a, cls2, do_close;
	mtt_result_t close_r, emit_r;

	always_comb begin
		token_n   = token_q;
		quote_n   = quote_q;
		comment_n = comment_q;
		held_v_n  = held_v_q;
		held_b_n  = held_b_q;
		tho_n     = tho_q;
		fin       = 1'b0;
		emit_a    = 1'b0;

		if (comment_q) begin
			if (c == ChNewline)
				comment_n = 1'b0;
		end else if (is_blank(c) && !quote_q) begin
			if (token_q) begin
				token_n = 1'b0;
				fin     = 1'b1;
			end
		end else if ((c == ChSlash) && (prev_q == ChSlash)) begin
			comment_n = 1'b1;
			token_n   = 1'b0;
			held_v_n  = 1'b0;
			if (tho_q)
				fin = 1'b1;
		end else if ((c == ChQuote) && seen_q && (prev_q != ChBackslash)) begin
			quote_n = !quote_q;
			if (quote_q) begin
				token_n = 1'b0;
				fin     = 1'b1;
			end
		end else begin
			token_n = 1'b1;
		end

		if (token_n) begin
			if (held_v_n) begin
				emit_a = 1'b1;
				tho_n  = 1'b1;
			end
			held_b_n = c;
			held_v_n = 1'b1;
		end

		close_r.token_byte   = held_v_n ? held_b_n : 8'd0;
		close_r.byte_present = held_v_n;
		close_r.token_end    = 1'b1;
		close_r.run_last     = 1'b1;

		cls2     = eoi && !fin && (held_v_n || tho_n);
		do_close = fin || cls2;

		if (fin) begin
			held_v_n = 1'b0;
			tho_n    = 1'b0;
		end

		emit_r.token_byte   = held_b_q;
		emit_r.byte_present = 1'b1;
		emit_r.token_end    = 1'b0;
		emit_r.run_last     = !do_close;

		push.count = step ? ({1'b0, emit_a} + {1'b0, do_close}) : 2'd0;
		push.res_a = emit_a ? emit_r : close_r;
		push.res_b = close_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q   <= 1'b0;
			quote_q   <= 1'b0;
			comment_q <= 1'b0;
			seen_q    <= 1'b0;
			held_v_q  <= 1'b0;
			tho_q     <= 1'b0;
			prev_q    <= 8'd0;
			held_b_q  <= 8'd0;
		end else if (step) begin
			if (eoi) begin
				token_q   <= 1'b0;
				quote_q   <= 1'b0;
				comment_q <= 1'b0;
				seen_q    <= 1'b0;
				held_v_q  <= 1'b0;
				tho_q     <= 1'b0;
				prev_q    <= 8'd0;
				held_b_q  <= 8'd0;
			end else begin
				token_q   <= token_n;
				quote_q   <= quote_n;
				comment_q <= comment_n;
				seen_q    <= 1'b1;
				held_v_q  <= held_v_n;
				tho_q     <= tho_n;
				prev_q    <= c;
				held_b_q  <= held_b_n;
			end
		end
	end

endmodule

### hdl/mtt_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_result_queue
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module mtt_result_queue
	import mtt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mtt_push_t   push,
	input  logic        pop,
	output mtt_result_t head,
	output mtt_qstat_t  stat
);

	mtt_result_t          entry_q [QDepth];
	logic [QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QLevelW-1:0]   level_q;
	logic [QPtrW-1:0]     wr_next;

	assign wr_next    = wr_ptr_q + QPtrW'(1);
	assign head       = entry_q[rd_ptr_q];
	assign stat.level = level_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entry_q[wr_ptr_q] <= push.res_a;
		if (push.count == 2'd2)
			entry_q[wr_next] <= push.res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			level_q <= level_q + QLevelW'(push.count) - QLevelW'(pop);
		end
	end

endmodule

### hdl/map_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// map_text_tokenizer
// Splits a raw text byte stream into tokens, one token byte per result.
// ----------------------------------------------------------------------------
// One text byte is accepted per clock cycle while the stage register is free
// or steps. Each accepted word is registered, decided against the tokenizer
// state once the queue has room, and its results (none, one or two) are
// written to a four-entry result queue whose head feeds the token port.
// Token bytes are held back by one byte, so a token's bytes come out one
// input byte late, and the last byte arrives with token_end set (or a bare
// end mark when nothing is held). Input is taken while the queue has room for
// two results; the sustained rate is one byte per cycle while the token port
// takes one result per cycle, and a byte with two results needs both taken.
`include "map_text_tokenizer_assert.svh"

module map_text_tokenizer
	import mtt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mtt_in_if.sink    text_in,
	mtt_out_if.source token_out
);

	logic        valid_s1;
	logic [7:0]  text_byte_s1;
	logic        end_of_input_s1;
	logic        step;
	logic        accept;
	logic        pop;
	mtt_push_t   push;
	mtt_result_t head;
	mtt_qstat_t  q_stat;

	assign step   = valid_s1 && (q_stat.level <= QLevelW'(QDepth - 2));
	assign accept = text_in.valid && text_in.ready;
	assign text_in.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			text_byte_s1    <= text_in.text_byte;
			end_of_input_s1 <= text_in.end_of_input;
		end
	end

	mtt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.c      (text_byte_s1),
		.eoi    (end_of_input_s1),
		.push   (push)
	);

	mtt_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	assign pop                    = token_out.valid && token_out.ready;
	assign token_out.valid        = (q_stat.level != '0);
	assign token_out.token_byte   = head.token_byte;
	assign token_out.byte_present = head.byte_present;
	assign token_out.token_end    = head.token_end;
	assign token_out.run_last     = head.run_last;

	`MTT_ASSERT(a_pair_shape, clk, arst_n, (push.count == 2'd2) |-> (!push.res_a.token_end && push.res_b.token_end && push.res_b.run_last && !push.res_a.run_last), "two results must be a token byte then a close")
	`MTT_ASSERT_NEVER(a_queue_over, clk, arst_n, (q_stat.level > QLevelW'(QDepth)), "result queue overfilled")
	`MTT_ASSERT(a_bare_mark, clk, arst_n, (token_out.valid && !token_out.byte_present) |-> (token_out.token_byte == 8'd0 && token_out.token_end), "bare mark must be an empty close")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for map_text_tokenizer. Feeds text bytes (directed
// corner cases, then random texts and noise) through bursty valid/ready
// traffic, predicts each token word in a scoreboard and compares every word
// taken from the token port against it, with the receiver stalling at random.
// ----------------------------------------------------------------------------
module tb;
	import mtt_pkg::*;

	localparam int TextWords  = 1600;
	localparam int CycleLimit = 400000;

	class token_scoreboard;
		bit          in_tok;
		bit          quote_open;
		bit          cmt_open;
		bit          seen_any;
		bit          held_ok;
		bit          tok_sent;
		logic [7:0]  prev_ch;
		logic [7:0]  held_ch;
		mtt_result_t step_res[2];
		int          step_n;
		mtt_result_t awaited_tokens[$];
		int          mismatch_count;

		function new();
			clear_text_state();
			mismatch_count = 0;
		endfunction

		function void clear_text_state();
			in_tok     = 1'b0;
			quote_open = 1'b0;
			cmt_open   = 1'b0;
			seen_any   = 1'b0;
			held_ok    = 1'b0;
			tok_sent   = 1'b0;
			prev_ch    = 8'h00;
			held_ch    = 8'h00;
		endfunction

		function void add_result(input logic [7:0] b, input logic present, input logic ends);
			step_res[step_n].token_byte   = b;
			step_res[step_n].byte_present = present;
			step_res[step_n].token_end    = ends;
			step_res[step_n].run_last     = 1'b0;
			step_n++;
		endfunction

		function void close_token();
			if (held_ok)
				add_result(held_ch, 1'b1, 1'b1);
			else
				add_result(8'h00, 1'b0, 1'b1);
			held_ok  = 1'b0;
			held_ch  = 8'h00;
			tok_sent = 1'b0;
		endfunction

		function void note_text_word(input logic [7:0] ch, input logic last_of_text);
			bit closing;
			bit blank;
			closing = 1'b0;
			step_n  = 0;
			blank   = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
			if (cmt_open) begin
				if (ch == ChNewline)
					cmt_open = 1'b0;
			end else if (blank && !quote_open) begin
				if (in_tok) begin
					in_tok  = 1'b0;
					closing = 1'b1;
				end
			end else if (ch == ChSlash && prev_ch == ChSlash) begin
				cmt_open = 1'b1;
				in_tok   = 1'b0;
				held_ok  = 1'b0;
				held_ch  = 8'h00;
				if (tok_sent)
					closing = 1'b1;
			end else if (ch == ChQuote && seen_any && prev_ch != ChBackslash) begin
				quote_open = !quote_open;
				if (!quote_open) begin
					in_tok  = 1'b0;
					closing = 1'b1;
				end
			end else begin
				in_tok = 1'b1;
			end
			if (in_tok) begin
				if (held_ok) begin
					add_result(held_ch, 1'b1, 1'b0);
					tok_sent = 1'b1;
				end
				held_ch = ch;
				held_ok = 1'b1;
			end
			prev_ch  = ch;
			seen_any = 1'b1;
			if (closing)
				close_token();
			if (last_of_text) begin
				if (held_ok || tok_sent)
					close_token();
				clear_text_state();
			end
			for (int i = 0; i < step_n; i++) begin
				step_res[i].run_last = (i == step_n - 1);
				awaited_tokens.push_back(step_res[i]);
			end
		endfunction

		function void check_token_word(input logic [7:0] b, input logic present,
			input logic ends, input logic last);
			mtt_result_t want;
			if (awaited_tokens.size() == 0) begin
				$error("token word %0h/%0b/%0b/%0b with nothing awaited", b, present, ends, last);
				mismatch_count++;
				return;
			end
			want = awaited_tokens.pop_front();
			if (b !== want.token_byte) begin
				$error("token_byte: expected %0h, got %0h", want.token_byte, b);
				mismatch_count++;
			end
			if (present !== want.byte_present) begin
				$error("byte_present: expected %0b, got %0b", want.byte_present, present);
				mismatch_count++;
			end
			if (ends !== want.token_end) begin
				$error("token_end: expected %0b, got %0b", want.token_end, ends);
				mismatch_count++;
			end
			if (last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, last);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mtt_in_if  text_if();
	mtt_out_if token_if();

	map_text_tokenizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_if),
		.token_out (token_if)
	);

	token_scoreboard tok_sb = new();

	int burst_left = 0;
	int words_sent = 0;
	int cycle_count = 0;
	int rx_tick = 0;
	int rx_mode = 0;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb failed");
			$finish;
		end
	end

	// token receiver: check taken words, stall in modes of its own
	always @(posedge clk) begin
		if (arst_n && token_if.valid && token_if.ready)
			tok_sb.check_token_word(token_if.token_byte, token_if.byte_present,
				token_if.token_end, token_if.run_last);
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0)
			rx_mode <= $urandom_range(0, 2);
		case (rx_mode)
			0: token_if.ready <= 1'b1;
			1: token_if.ready <= $urandom_range(0, 1);
			default: token_if.ready <= (rx_tick % 8 == 0);
		endcase
	end

	task automatic send_text_word(input logic [7:0] ch, input logic last_of_text);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				text_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_if.valid        <= 1'b1;
		text_if.text_byte    <= ch;
		text_if.end_of_input <= last_of_text;
		do
			@(posedge clk);
		while (!(text_if.valid && text_if.ready));
		tok_sb.note_text_word(ch, last_of_text);
		words_sent++;
	endtask

	// hold the sender until every awaited word has come
	task automatic drain_tokens();
		text_if.valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (tok_sb.awaited_tokens.size() != 0);
	endtask

	function automatic logic [7:0] pick_text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'($urandom_range(8'h61, 8'h7A));
		else if (r < 52)
			return ($urandom_range(0, 1) == 0) ? ChSpace : 8'($urandom_range(ChTab, ChCr));
		else if (r < 62)
			return ChQuote;
		else if (r < 74)
			return ChSlash;
		else if (r < 79)
			return ChBackslash;
		else if (r < 85)
			return ChNewline;
		else if (r < 92)
			return 8'($urandom_range(128, 255));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic run_directed();
		send_text_word(ChQuote, 1'b0);
		send_text_word("a", 1'b0);
		send_text_word(ChSpace, 1'b0);
		send_text_word(ChQuote, 1'b0);
		send_text_word(ChQuote, 1'b0);
		send_text_word(ChBackslash, 1'b0);
		send_text_word(ChQuote, 1'b0);
		send_text_word(ChTab, 1'b0);
		send_text_word(ChQuote, 1'b0);
		send_text_word(ChSlash, 1'b0);
		send_text_word(ChSlash, 1'b0);
		send_text_word("z", 1'b0);
		send_text_word(ChNewline, 1'b0);
		send_text_word(8'hFF, 1'b0);
		send_text_word(8'h80, 1'b0);
		send_text_word(ChSlash, 1'b0);
		send_text_word(ChSlash, 1'b0);
		send_text_word(ChNewline, 1'b0);
		send_text_word(8'h00, 1'b0);
		send_text_word(8'h0B, 1'b0);
		send_text_word(8'h0C, 1'b0);
		send_text_word(ChCr, 1'b0);
		send_text_word(ChSlash, 1'b0);
		send_text_word(ChSlash, 1'b0);
		send_text_word(8'h7F, 1'b1);
		send_text_word("q", 1'b1);
	endtask

	task automatic run_random();
		int len;
		while (words_sent < TextWords) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_text_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				len = $urandom_range(1, 40);
				for (int i = 0; i < len; i++)
					send_text_word(pick_text_char(), i == len - 1);
			end
			if ($urandom_range(0, 19) == 0)
				drain_tokens();
		end
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		text_if.valid        = 1'b0;
		text_if.text_byte    = 8'h00;
		text_if.end_of_input = 1'b0;
		token_if.ready       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain_tokens();
		run_random();
		text_if.valid <= 1'b0;
		while (tok_sb.awaited_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tok_sb.mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
